/* rtl/etmc_pkg.sv */
`default_nettype none
package etmc_pkg;

    localparam int FRAC_BITS          = 16;
    localparam int MAX_PREDICT_FRAMES = 4096;
    localparam int CNT_W              = 16;
    localparam logic [CNT_W-1:0] SETTLE_FRAMES = 16'd60;
    localparam logic [CNT_W-1:0] CHIME_FRAMES  = 16'd30;
    localparam logic [CNT_W-1:0] PREDICT_LIMIT = CNT_W'(MAX_PREDICT_FRAMES);

    typedef enum logic [1:0] {
        MODE_REST = 2'd0,
        MODE_MOVE = 2'd1,
        MODE_STOP = 2'd2
    } run_mode_t;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_UP    = 2'd2,
        ACT_DOWN  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        REG_FLOOR_COUNT  = 3'd0,
        REG_START_FLOOR  = 3'd1,
        REG_START_HEIGHT = 3'd2,
        REG_TOP_SPEED    = 3'd3,
        REG_ACCEL_STEP   = 3'd4,
        REG_RAMP_LIMIT   = 3'd5
    } reg_index_t;

    typedef enum logic [1:0] {
        SEQ_IDLE    = 2'd0,
        SEQ_PREDICT = 2'd1,
        SEQ_OUT     = 2'd2
    } seq_state_t;

    // Saturate a 34-bit signed sum to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -34'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [32:0] mag(input logic signed [31:0] v);
        logic signed [32:0] w;
        w = {v[31], v};
        return v[31] ? 33'(-w) : 33'(w);
    endfunction

endpackage
`default_nettype wire

/* rtl/elevator_trapezoid_motion_controller.sv */
`default_nettype none
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+--------------------------------------
// input    | in        | in_valid/in_ready  | action, target_height
// result   | out       | out_valid/out_ready| car_height .. area_enabled (10 fields)
// config   | in        | cfg_we             | cfg_index, cfg_data
//
// A tick, a query or a refused request is accepted and evaluated in SEQ_IDLE,
// and its result beat is then presented in SEQ_OUT. An accepted move request
// first runs the arrival prediction on the shared profile step unit in
// SEQ_PREDICT, one predicted frame per cycle, until arrival or until the
// prediction counter reaches MAX_PREDICT_FRAMES.
// Reset is asynchronous and active low; no clearing pass is needed.
// The block takes one item at a time: in_ready is low while an item is being
// worked on or its result beat waits for out_ready.
module elevator_trapezoid_motion_controller (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire  [1:0]          action,
    input  wire  signed [31:0]  target_height,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic signed [31:0]  car_height,
    output logic [7:0]          floor_index,
    output logic [1:0]          mode,
    output logic                can_go_up,
    output logic                can_go_down,
    output logic                cue_start,
    output logic                cue_refused,
    output logic                cue_chime,
    output logic                cue_arrived,
    output logic                area_enabled,
    input  wire                 cfg_we,
    input  wire  [2:0]          cfg_index,
    input  wire  [31:0]         cfg_data
);
    import etmc_pkg::*;

    // Configuration registers. The start floor and start height act only
    // through the car state that a write to them loads.
    logic [7:0]         floor_count_reg;
    logic [24:0]        top_speed_reg;
    logic [24:0]        accel_step_reg;
    logic [30:0]        ramp_limit_reg;

    // Architectural state.
    run_mode_t          run_mode_reg, run_mode_next;
    logic [7:0]         cur_floor_reg, cur_floor_next;
    logic [7:0]         pend_floor_reg, pend_floor_next;
    logic signed [31:0] height_reg, height_next;
    logic signed [31:0] goal_reg, goal_next;
    logic signed [31:0] vel_reg, vel_next;
    logic signed [31:0] done_reg, done_next;
    logic signed [31:0] left_reg, left_next;
    logic signed [31:0] ramp_reg, ramp_next;
    logic signed [31:0] step_reg, step_next;
    logic [CNT_W-1:0]   elapsed_reg, elapsed_next;
    logic [CNT_W-1:0]   predicted_reg, predicted_next;
    logic               area_reg, area_next;

    // Prediction working registers, fed through the shared step unit.
    logic signed [31:0] p_done_reg, p_done_next;
    logic signed [31:0] p_left_reg, p_left_next;
    logic signed [31:0] p_vel_reg, p_vel_next;
    logic [CNT_W-1:0]   p_cnt_reg, p_cnt_next;

    seq_state_t         state_reg, state_next;

    // Output register.
    logic               up_reg, up_next, dn_reg, dn_next;
    logic               cs_reg, cs_next, cr_reg, cr_next;
    logic               ch_reg, ch_next, ca_reg, ca_next;

    // Shared profile step unit: one frame of the trapezoid.
    logic signed [31:0] u_v, u_done, u_left, u_nv, u_ndone, u_nleft;
    logic               u_arr;
    logic signed [31:0] top_pos;

    always_comb
    begin
        top_pos = 32'(signed'({1'b0, top_speed_reg}));
        if (mag(ramp_reg) <= mag(u_done)) begin
            if (mag(ramp_reg) <= mag(u_left))
                u_nv = (u_left <= 32'sd0) ? -top_pos : top_pos;
            else
                u_nv = sat32(34'(u_v) - 34'(step_reg));
        end else begin
            u_nv = sat32(34'(u_v) + 34'(step_reg));
        end
        u_ndone = sat32(34'(u_done) + 34'(u_nv));
        u_nleft = sat32(34'(u_left) - 34'(u_nv));
        u_arr = (u_v < 0 && u_nv >= 0) || (u_v > 0 && u_nv <= 0)
                || (mag(u_nleft) < mag(u_nv));
    end

    // The unit sees the prediction registers while predicting, else the car.
    always_comb
    begin
        if (state_reg == SEQ_PREDICT) begin
            u_v = p_vel_reg; u_done = p_done_reg; u_left = p_left_reg;
        end else begin
            u_v = vel_reg; u_done = done_reg; u_left = left_reg;
        end
    end

    // Start-of-move planning.
    logic signed [31:0] dist_sat, half, ramp_pos;
    logic [32:0]        twice_limit;
    logic signed [15:0] remaining;
    always_comb
    begin
        dist_sat = sat32(34'(target_height) - 34'(height_reg));
        half = dist_sat / 32'sd2;
        twice_limit = {1'b0, ramp_limit_reg, 1'b0};
        ramp_pos = (mag(dist_sat) <= twice_limit) ? half
                   : 32'(signed'({1'b0, ramp_limit_reg}));
        remaining = signed'(predicted_reg) - signed'(elapsed_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        run_mode_next = run_mode_reg;
        cur_floor_next = cur_floor_reg;
        pend_floor_next = pend_floor_reg;
        height_next = height_reg;
        goal_next = goal_reg;
        vel_next = vel_reg;
        done_next = done_reg;
        left_next = left_reg;
        ramp_next = ramp_reg;
        step_next = step_reg;
        elapsed_next = elapsed_reg;
        predicted_next = predicted_reg;
        area_next = area_reg;
        p_done_next = p_done_reg;
        p_left_next = p_left_reg;
        p_vel_next = p_vel_reg;
        p_cnt_next = p_cnt_reg;
        up_next = up_reg; dn_next = dn_reg; cs_next = cs_reg;
        cr_next = cr_reg; ch_next = ch_reg; ca_next = ca_reg;
        in_ready = 1'b0;
        out_valid = 1'b0;

        case (state_reg)
            SEQ_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    up_next = 1'b0; dn_next = 1'b0; cs_next = 1'b0;
                    cr_next = 1'b0; ch_next = 1'b0; ca_next = 1'b0;
                    state_next = SEQ_OUT;
                    if (action == ACT_TICK) begin
                        if (run_mode_reg == MODE_STOP) begin
                            if (elapsed_reg > SETTLE_FRAMES)
                                run_mode_next = MODE_REST;
                        end else if (run_mode_reg == MODE_MOVE) begin
                            vel_next = u_nv;
                            height_next = sat32(34'(height_reg) + 34'(u_nv));
                            done_next = u_ndone;
                            left_next = u_nleft;
                            ch_next = (remaining == 16'(CHIME_FRAMES));
                            if (u_arr) begin
                                height_next = goal_reg;
                                run_mode_next = MODE_STOP;
                                cur_floor_next = pend_floor_reg;
                                area_next = 1'b1;
                                ca_next = 1'b1;
                            end
                        end
                        if (run_mode_reg == MODE_MOVE && u_arr)
                            elapsed_next = CNT_W'(1);
                        else if (elapsed_reg != '1)
                            elapsed_next = elapsed_reg + CNT_W'(1);
                    end else if (run_mode_reg == MODE_REST) begin
                        if (action == ACT_QUERY) begin
                            up_next = ({1'b0, cur_floor_reg} + 9'd1)
                                      < {1'b0, floor_count_reg};
                            dn_next = (cur_floor_reg != 8'd0);
                        end else if ((action == ACT_UP &&
                                      ({1'b0, cur_floor_reg} + 9'd1)
                                      < {1'b0, floor_count_reg}) ||
                                     (action == ACT_DOWN && cur_floor_reg != 8'd0 &&
                                      (cur_floor_reg - 8'd1) < floor_count_reg)) begin
                            pend_floor_next = (action == ACT_UP) ?
                                              cur_floor_reg + 8'd1 : cur_floor_reg - 8'd1;
                            goal_next = target_height;
                            done_next = 32'sd0;
                            left_next = dist_sat;
                            vel_next = 32'sd0;
                            if (dist_sat < 0) begin
                                step_next = -32'(signed'({1'b0, accel_step_reg}));
                                ramp_next = sat32(-34'(ramp_pos));
                            end else begin
                                step_next = 32'(signed'({1'b0, accel_step_reg}));
                                ramp_next = ramp_pos;
                            end
                            run_mode_next = MODE_MOVE;
                            elapsed_next = '0;
                            area_next = 1'b0;
                            cs_next = 1'b1;
                            p_done_next = 32'sd0;
                            p_left_next = dist_sat;
                            p_vel_next = 32'sd0;
                            p_cnt_next = '0;
                            state_next = SEQ_PREDICT;
                        end else begin
                            cr_next = 1'b1;
                        end
                    end
                end
            end
            SEQ_PREDICT:
            begin
                // One predicted frame per cycle on the shared unit.
                if (p_cnt_reg >= PREDICT_LIMIT) begin
                    predicted_next = p_cnt_reg;
                    state_next = SEQ_OUT;
                end else begin
                    p_done_next = u_ndone;
                    p_left_next = u_nleft;
                    if (u_arr) begin
                        predicted_next = p_cnt_reg;
                        state_next = SEQ_OUT;
                    end else begin
                        p_cnt_next = p_cnt_reg + CNT_W'(1);
                        p_vel_next = u_nv;
                    end
                end
            end
            SEQ_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = SEQ_IDLE;
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase

        // The user must make configuration writes only while idle; not enforced.
        if (cfg_we) begin
            case (cfg_index)
                REG_START_FLOOR:
                begin
                    cur_floor_next = cfg_data[7:0];
                    pend_floor_next = cfg_data[7:0];
                end
                REG_START_HEIGHT: height_next = signed'(cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            floor_count_reg  <= 8'd4;
            top_speed_reg    <= 25'd65536;
            accel_step_reg   <= 25'd6554;
            ramp_limit_reg   <= 31'd327680;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FLOOR_COUNT:  floor_count_reg  <= cfg_data[7:0];
                REG_TOP_SPEED:    top_speed_reg    <= cfg_data[24:0];
                REG_ACCEL_STEP:   accel_step_reg   <= cfg_data[24:0];
                REG_RAMP_LIMIT:   ramp_limit_reg   <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= SEQ_IDLE;
            run_mode_reg   <= MODE_REST;
            cur_floor_reg  <= 8'd0;
            pend_floor_reg <= 8'd0;
            height_reg     <= 32'sd0;
            goal_reg       <= 32'sd0;
            vel_reg        <= 32'sd0;
            done_reg       <= 32'sd0;
            left_reg       <= 32'sd0;
            ramp_reg       <= 32'sd0;
            step_reg       <= 32'sd0;
            elapsed_reg    <= '0;
            predicted_reg  <= '0;
            area_reg       <= 1'b1;
            p_cnt_reg      <= '0;
            up_reg <= 1'b0; dn_reg <= 1'b0; cs_reg <= 1'b0;
            cr_reg <= 1'b0; ch_reg <= 1'b0; ca_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            run_mode_reg   <= run_mode_next;
            cur_floor_reg  <= cur_floor_next;
            pend_floor_reg <= pend_floor_next;
            height_reg     <= height_next;
            goal_reg       <= goal_next;
            vel_reg        <= vel_next;
            done_reg       <= done_next;
            left_reg       <= left_next;
            ramp_reg       <= ramp_next;
            step_reg       <= step_next;
            elapsed_reg    <= elapsed_next;
            predicted_reg  <= predicted_next;
            area_reg       <= area_next;
            p_cnt_reg      <= p_cnt_next;
            up_reg <= up_next; dn_reg <= dn_next; cs_reg <= cs_next;
            cr_reg <= cr_next; ch_reg <= ch_next; ca_reg <= ca_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_done_reg <= p_done_next;
        p_left_reg <= p_left_next;
        p_vel_reg  <= p_vel_next;
    end

    assign car_height   = height_reg;
    assign floor_index  = cur_floor_reg;
    assign mode         = run_mode_reg;
    assign can_go_up    = up_reg;
    assign can_go_down  = dn_reg;
    assign cue_start    = cs_reg;
    assign cue_refused  = cr_reg;
    assign cue_chime    = ch_reg;
    assign cue_arrived  = ca_reg;
    assign area_enabled = area_reg;

    // A beat never carries two opposing cues.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(cue_start && cue_refused))
        else $error("start and refusal cues together");

    // An arrival always leaves the car settling with the area on.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && cue_arrived) |-> (mode == MODE_STOP && area_enabled))
        else $error("arrival without settling");

    // The prediction counter never runs past its bound.
    assert property (@(posedge clk) disable iff (!rst_n)
        p_cnt_reg <= PREDICT_LIMIT)
        else $error("prediction counter overran");

    // An accepted start leaves the car moving with the area off.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && cue_start) |-> (mode == MODE_MOVE && !area_enabled))
        else $error("start cue without motion");

endmodule
`default_nettype wire
